@@ rtl/rpbf_pkg.sv @@
// shared types, codes and constants of the rate paced byte fifo
`default_nettype none
package rpbf_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 65536;
	localparam int unsigned CAP_MAX          = 131071;

	localparam int unsigned CFG_W    = 30;
	localparam int unsigned TARGET_W = 30;
	localparam int unsigned CAP_W    = 17;
	localparam int unsigned CHUNK_W  = 12;
	localparam int unsigned WIN_W    = 16;
	localparam int unsigned LEN_W    = 12;
	localparam int unsigned CNT_W    = 17;
	localparam int unsigned OCC_W    = 18;
	localparam int unsigned OUTS_W   = 12;
	localparam int unsigned DROP_W   = 11;
	localparam int unsigned ELAP_W   = 32;
	localparam int unsigned TOTAL_W  = 48;
	localparam int unsigned SCALE_W  = 13;
	localparam int unsigned GSCL_W   = LEN_W + SCALE_W;
	localparam int unsigned LHS_W    = 45;
	localparam int unsigned RHS_W    = TARGET_W + ELAP_W;

	localparam logic [LEN_W-1:0]   MAX_DGRAM  = 12'd2048;
	localparam logic [CHUNK_W-1:0] MAX_CHUNK  = 12'd2048;
	localparam logic [SCALE_W-1:0] RATE_SCALE = 13'd8000;
	localparam logic [LHS_W-1:0]   LHS_SAT    = LHS_W'(64'hFFFF_FFFF * 64'd8000);

	localparam logic [TARGET_W-1:0] TARGET_RST = 30'd8000000;
	localparam logic [CAP_W-1:0]    CAP_RST    = 17'd65536;
	localparam logic [CHUNK_W-1:0]  CHUNK_RST  = 12'd1316;
	localparam logic [WIN_W-1:0]    WIN_RST    = 16'd300;

	typedef enum logic [1:0] {
		ACT_RECV = 2'd0,
		ACT_TICK = 2'd1,
		ACT_PULL = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_TARGET   = 2'd0,
		REG_CAPACITY = 2'd1,
		REG_CHUNK    = 2'd2,
		REG_WINDOW   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_GRANT = 1'b0,
		KIND_BYTE  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [LEN_W-1:0]    chunk_len;
		logic                last;
		logic [TOTAL_W-1:0]  total;
	} res_t;

	typedef struct packed {
		logic pass;
		logic busy;
	} pacer_stat_t;

endpackage
`default_nettype wire

@@ rtl/rpbf_ring.sv @@
// byte ring memory, one write and one registered read per cycle
`default_nettype none
module rpbf_ring #(
	parameter int unsigned DEPTH = rpbf_pkg::BUFFER_BYTES_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/rpbf_pacer.sv @@
// rate test: elapsed time, window byte count and their running products
`default_nettype none
module rpbf_pacer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             tick,
	input  wire logic                             recalc,
	input  wire logic [rpbf_pkg::TARGET_W-1:0]    target,
	input  wire logic [rpbf_pkg::WIN_W-1:0]       window_ms,
	input  wire logic [rpbf_pkg::LEN_W-1:0]       grant_len,
	output rpbf_pkg::pacer_stat_t                 stat
);

	localparam int unsigned EW = rpbf_pkg::ELAP_W;
	localparam int unsigned LW = rpbf_pkg::LHS_W;
	localparam int unsigned RW = rpbf_pkg::RHS_W;
	localparam int unsigned GW = rpbf_pkg::GSCL_W;

	logic [EW-1:0] elapsed_q;
	logic [EW-1:0] window_q;
	logic [LW-1:0] lhs_q;
	logic [RW-1:0] rhs_q;
	logic          busy_q;

	logic          elap_sat;
	logic [EW-1:0] elapsed_inc;
	logic [RW-1:0] rhs_inc;
	logic          pass;
	logic          restart;
	logic [EW-1:0] win_base;
	logic [LW-1:0] lhs_base;
	logic [EW:0]   win_sum;
	logic [GW-1:0] grant_scaled;

	always_comb begin
		elap_sat     = &elapsed_q;
		elapsed_inc  = elap_sat ? elapsed_q : elapsed_q + EW'(1);
		rhs_inc      = elap_sat ? rhs_q : rhs_q + RW'(target);
		pass         = tick && (LW'(lhs_q) < rhs_inc);
		restart      = pass && (elapsed_inc >= EW'(window_ms));
		win_base     = restart ? '0 : window_q;
		lhs_base     = restart ? '0 : lhs_q;
		win_sum      = {1'b0, win_base} + (EW + 1)'(grant_len);
		grant_scaled = GW'(grant_len) * GW'(rpbf_pkg::RATE_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			window_q  <= '0;
			lhs_q     <= '0;
			rhs_q     <= '0;
			busy_q    <= 1'b0;
		end else begin
			busy_q <= recalc;
			if (busy_q) begin
				rhs_q <= RW'(target) * RW'(elapsed_q);
			end else if (tick) begin
				elapsed_q <= restart ? '0 : elapsed_inc;
				rhs_q     <= restart ? '0 : rhs_inc;
				if (pass) begin
					if (win_sum[EW]) begin
						window_q <= '1;
						lhs_q    <= rpbf_pkg::LHS_SAT;
					end else begin
						window_q <= win_sum[EW-1:0];
						lhs_q    <= lhs_base + LW'(grant_scaled);
					end
				end
			end
		end
	end

	assign stat.pass = pass;
	assign stat.busy = busy_q;

endmodule
`default_nettype wire

@@ rtl/rpbf_out_stage.sv @@
// result pipeline: memory read stage and output register
`default_nettype none
module rpbf_out_stage (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load,
	input  wire rpbf_pkg::res_t                   res,
	input  wire logic [7:0]                       rdata,
	output logic                                  free,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  kind,
	output logic [rpbf_pkg::LEN_W-1:0]            chunk_len,
	output logic [7:0]                            out_byte,
	output logic                                  last_of_chunk,
	output logic [rpbf_pkg::TOTAL_W-1:0]          total_sent
);

	logic           valid_s1;
	rpbf_pkg::res_t res_s1;
	logic           valid_q;
	rpbf_pkg::res_t res_q;
	logic [7:0]     byte_q;
	logic           out_take;

	assign out_take = !valid_q || out_ready;
	assign free     = !valid_s1 || out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (free) begin
				valid_s1 <= load;
			end
			if (out_take) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s1 <= res;
		end
		if (out_take && valid_s1) begin
			res_q  <= res_s1;
			byte_q <= (res_s1.kind == rpbf_pkg::KIND_BYTE) ? rdata : 8'd0;
		end
	end

	assign out_valid     = valid_q;
	assign kind          = res_q.kind;
	assign chunk_len     = res_q.chunk_len;
	assign out_byte      = byte_q;
	assign last_of_chunk = res_q.last;
	assign total_sent    = res_q.total;

endmodule
`default_nettype wire

@@ rtl/rate_paced_byte_fifo.sv @@
// rate paced byte fifo top level: config registers, ring pointers and counts
//
// Bytes of datagrams are written into a ring memory and released in chunks
// at a paced bit rate. The block accepts one word (receive byte, millisecond
// tick or pull) per clock while in_ready is high; the ring memory has one
// write and one read port, a receive writes and a pull reads. A grant result
// or a pulled byte passes the registered memory read stage and then the
// output register, and either can hold it while out_ready is low. After a
// write to the target rate register, in_ready is low for one cycle while
// the product of target rate and elapsed time is rebuilt.
// There is no clearing pass after reset; the ring contents start undefined
// and only bytes that were written are ever granted.
`default_nettype none
module rate_paced_byte_fifo #(
	parameter int unsigned BUFFER_BYTES = rpbf_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [rpbf_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        action,
	input  wire logic [7:0]                        data_byte,
	input  wire logic [rpbf_pkg::LEN_W-1:0]        datagram_len,
	input  wire logic                              first_of_datagram,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   kind,
	output logic [rpbf_pkg::LEN_W-1:0]             chunk_len,
	output logic [7:0]                             out_byte,
	output logic                                   last_of_chunk,
	output logic [rpbf_pkg::TOTAL_W-1:0]           total_sent
);

	localparam int unsigned AW      = $clog2(BUFFER_BYTES);
	localparam int unsigned CAP_LIM = (BUFFER_BYTES > rpbf_pkg::CAP_MAX) ?
		rpbf_pkg::CAP_MAX : BUFFER_BYTES;
	localparam int unsigned CW  = rpbf_pkg::CNT_W;
	localparam int unsigned OW  = rpbf_pkg::OCC_W;
	localparam int unsigned SW  = rpbf_pkg::OUTS_W;
	localparam int unsigned DW  = rpbf_pkg::DROP_W;
	localparam int unsigned LW  = rpbf_pkg::LEN_W;
	localparam int unsigned TW  = rpbf_pkg::TOTAL_W;
	localparam logic [AW:0]   BUF_SIZE = (AW + 1)'(BUFFER_BYTES);
	localparam logic [AW-1:0] BUF_LAST = AW'(BUFFER_BYTES - 1);

	logic [rpbf_pkg::TARGET_W-1:0] target_q;
	logic [rpbf_pkg::CAP_W-1:0]    capacity_q;
	logic [rpbf_pkg::CHUNK_W-1:0]  chunk_q;
	logic [rpbf_pkg::WIN_W-1:0]    window_q;

	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] queued_q;
	logic [SW-1:0] outs_q;
	logic [DW-1:0] drop_q;
	logic [TW-1:0] total_q;

	rpbf_pkg::pacer_stat_t pstat;
	rpbf_pkg::res_t        res;

	logic          stage_free;
	logic          acc;
	logic          is_recv;
	logic          is_tick;
	logic          is_pull;
	logic          recalc;
	logic [CW-1:0] usable;
	logic [OW-1:0] occupied;
	logic [LW-1:0] len_eff;
	logic          overflow;
	logic          skip;
	logic          store;
	logic          flush;
	logic [AW:0]   flush_sum;
	logic [AW-1:0] flush_wp;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] rp_inc;
	logic [LW-1:0] limit;
	logic [LW-1:0] grant_len;
	logic          grant_fire;
	logic          pull_fire;
	logic [7:0]    rdata;

	assign in_ready = stage_free && !pstat.busy;
	assign acc      = in_valid && in_ready;
	assign is_recv  = acc && (action == rpbf_pkg::ACT_RECV);
	assign is_tick  = acc && (action == rpbf_pkg::ACT_TICK);
	assign is_pull  = acc && (action == rpbf_pkg::ACT_PULL);
	assign recalc   = cfg_we && (cfg_index == rpbf_pkg::REG_TARGET);

	always_comb begin
		usable   = (capacity_q > CW'(CAP_LIM)) ? CW'(CAP_LIM) : capacity_q;
		occupied = OW'(outs_q) + OW'(queued_q);
		if (datagram_len == '0) begin
			len_eff = LW'(1);
		end else if (datagram_len > rpbf_pkg::MAX_DGRAM) begin
			len_eff = rpbf_pkg::MAX_DGRAM;
		end else begin
			len_eff = datagram_len;
		end
		overflow  = first_of_datagram && ((occupied + OW'(len_eff)) > OW'(usable));
		skip      = !first_of_datagram && (drop_q != '0);
		flush     = is_recv && overflow;
		store     = is_recv && !overflow && !skip && (occupied < OW'(usable));
		flush_sum = (AW + 1)'(rp_q) + (AW + 1)'(outs_q);
		flush_wp  = (flush_sum >= BUF_SIZE) ? AW'(flush_sum - BUF_SIZE) : AW'(flush_sum);
		wp_inc    = (wp_q == BUF_LAST) ? '0 : wp_q + AW'(1);
		rp_inc    = (rp_q == BUF_LAST) ? '0 : rp_q + AW'(1);

		limit = (chunk_q > rpbf_pkg::MAX_CHUNK) ? rpbf_pkg::MAX_CHUNK : chunk_q;
		if (pstat.pass && (outs_q == '0) && (queued_q != '0)) begin
			grant_len = (queued_q < CW'(limit)) ? LW'(queued_q) : limit;
		end else begin
			grant_len = '0;
		end
		grant_fire = grant_len != '0;
		pull_fire  = is_pull && (outs_q != '0);

		res.kind      = grant_fire ? rpbf_pkg::KIND_GRANT : rpbf_pkg::KIND_BYTE;
		res.chunk_len = grant_fire ? grant_len : '0;
		res.last      = pull_fire && (outs_q == SW'(1));
		res.total     = grant_fire ? total_q + TW'(grant_len) : total_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= rpbf_pkg::TARGET_RST;
			capacity_q <= rpbf_pkg::CAP_RST;
			chunk_q    <= rpbf_pkg::CHUNK_RST;
			window_q   <= rpbf_pkg::WIN_RST;
		end else if (cfg_we) begin
			unique case (rpbf_pkg::reg_idx_t'(cfg_index))
				rpbf_pkg::REG_TARGET:   target_q   <= cfg_data[rpbf_pkg::TARGET_W-1:0];
				rpbf_pkg::REG_CAPACITY: capacity_q <= cfg_data[rpbf_pkg::CAP_W-1:0];
				rpbf_pkg::REG_CHUNK:    chunk_q    <= cfg_data[rpbf_pkg::CHUNK_W-1:0];
				rpbf_pkg::REG_WINDOW:   window_q   <= cfg_data[rpbf_pkg::WIN_W-1:0];
			endcase
		end
	end

	// ring pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			queued_q <= '0;
			outs_q   <= '0;
			drop_q   <= '0;
			total_q  <= '0;
		end else begin
			if (is_recv) begin
				if (first_of_datagram) begin
					drop_q <= overflow ? DW'(len_eff - LW'(1)) : '0;
				end else if (skip) begin
					drop_q <= drop_q - DW'(1);
				end
				if (flush) begin
					wp_q     <= flush_wp;
					queued_q <= '0;
				end else if (store) begin
					wp_q     <= wp_inc;
					queued_q <= queued_q + CW'(1);
				end
			end
			if (grant_fire) begin
				queued_q <= queued_q - CW'(grant_len);
				outs_q   <= SW'(grant_len);
				total_q  <= total_q + TW'(grant_len);
			end
			if (pull_fire) begin
				rp_q   <= rp_inc;
				outs_q <= outs_q - SW'(1);
			end
		end
	end

	rpbf_ring #(
		.DEPTH (BUFFER_BYTES),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (store),
		.waddr (wp_q),
		.wdata (data_byte),
		.re    (pull_fire),
		.raddr (rp_q),
		.rdata (rdata)
	);

	rpbf_pacer u_pacer (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (is_tick),
		.recalc    (recalc),
		.target    (target_q),
		.window_ms (window_q),
		.grant_len (grant_len),
		.stat      (pstat)
	);

	rpbf_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (grant_fire || pull_fire),
		.res           (res),
		.rdata         (rdata),
		.free          (stage_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.chunk_len     (chunk_len),
		.out_byte      (out_byte),
		.last_of_chunk (last_of_chunk),
		.total_sent    (total_sent)
	);

endmodule
`default_nettype wire

@@ tb/tb_rate_paced_byte_fifo.sv @@
// testbench of the rate paced byte fifo: directed and random traffic against a predictor
`default_nettype none
module tb_rate_paced_byte_fifo;
	import rpbf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  ACT_UNUSED      = 2'd3;
	localparam int unsigned BUF_BYTES       = BUFFER_BYTES_DEF;
	localparam int unsigned HOLD_CYCLES     = 500;
	localparam int unsigned ITEMS_PER_PHASE = 190;
	localparam int unsigned QUIET_CYCLES    = 8;
	localparam int unsigned STREAM_BYTES    = 100;

	typedef struct {
		kind_t              kind;
		logic [LEN_W-1:0]   chunk_len;
		logic [7:0]         byte_val;
		logic               last;
		logic [TOTAL_W-1:0] total;
	} paced_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	reg_idx_t            cfg_index = REG_TARGET;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          action = ACT_RECV;
	logic [7:0]          data_byte = '0;
	logic [LEN_W-1:0]    datagram_len = '0;
	logic                first_of_datagram = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                kind;
	logic [LEN_W-1:0]    chunk_len;
	logic [7:0]          out_byte;
	logic                last_of_chunk;
	logic [TOTAL_W-1:0]  total_sent;

	// predictor state
	logic [7:0]          ring_copy [BUF_BYTES];
	logic [15:0]         wr_pos = '0;
	logic [15:0]         rd_pos = '0;
	int unsigned         queued_bytes = 0;
	int unsigned         granted_left = 0;
	int unsigned         drop_left = 0;
	logic [31:0]         elapsed_ticks = '0;
	logic [31:0]         window_count = '0;
	logic [TOTAL_W-1:0]  sent_total = '0;
	logic [TARGET_W-1:0] rate_bps = TARGET_RST;
	logic [CAP_W-1:0]    cap_limit = CAP_RST;
	logic [CHUNK_W-1:0]  chunk_limit = CHUNK_RST;
	logic [WIN_W-1:0]    window_len = WIN_RST;

	paced_word_t         expected_words [$];
	int unsigned         mismatches = 0;
	logic                gaps_on = 1'b1;
	int unsigned         hold_reqs_made = 0;
	int unsigned         hold_reqs_seen = 0;
	int unsigned         hold_left = 0;

	rate_paced_byte_fifo u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.data_byte         (data_byte),
		.datagram_len      (datagram_len),
		.first_of_datagram (first_of_datagram),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.chunk_len         (chunk_len),
		.out_byte          (out_byte),
		.last_of_chunk     (last_of_chunk),
		.total_sent        (total_sent)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void predict_word(logic [1:0] act, logic [7:0] b, logic [LEN_W-1:0] len,
			logic first);
		int unsigned occ, usable, dlen, lim, n;
		paced_word_t w;
		usable = (cap_limit < BUF_BYTES) ? int'(cap_limit) : BUF_BYTES;
		occ = granted_left + queued_bytes;
		case (act)
		ACT_RECV: begin
			if (first) begin
				drop_left = 0;
				dlen = (len == 0) ? 1 : ((len > MAX_DGRAM) ? int'(MAX_DGRAM) : int'(len));
				if (occ + dlen > usable) begin
					wr_pos = rd_pos + 16'(granted_left);
					queued_bytes = 0;
					drop_left = dlen - 1;
					return;
				end
			end else if (drop_left != 0) begin
				drop_left--;
				return;
			end
			if (occ >= usable)
				return;
			ring_copy[wr_pos] = b;
			wr_pos++;
			queued_bytes++;
		end
		ACT_TICK: begin
			if (elapsed_ticks != '1)
				elapsed_ticks++;
			if (!(64'(window_count) * 64'(RATE_SCALE) < 64'(rate_bps) * 64'(elapsed_ticks)))
				return;
			if (elapsed_ticks >= 32'(window_len)) begin
				elapsed_ticks = '0;
				window_count = '0;
			end
			if (granted_left != 0 || queued_bytes == 0)
				return;
			lim = (chunk_limit > MAX_CHUNK) ? int'(MAX_CHUNK) : int'(chunk_limit);
			n = (queued_bytes < lim) ? queued_bytes : lim;
			if (n == 0)
				return;
			queued_bytes -= n;
			granted_left = n;
			window_count = (window_count > 32'hFFFF_FFFF - n) ? '1 : window_count + n;
			sent_total = sent_total + TOTAL_W'(n);
			w.kind = KIND_GRANT;
			w.chunk_len = LEN_W'(n);
			w.byte_val = '0;
			w.last = 1'b0;
			w.total = sent_total;
			expected_words.push_back(w);
		end
		ACT_PULL: begin
			if (granted_left == 0)
				return;
			w.byte_val = ring_copy[rd_pos];
			rd_pos++;
			granted_left--;
			w.kind = KIND_BYTE;
			w.chunk_len = '0;
			w.last = (granted_left == 0);
			w.total = sent_total;
			expected_words.push_back(w);
		end
		default: ;
		endcase
	endfunction

	function automatic void cmp_field(string name, logic [TOTAL_W-1:0] want,
			logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_word();
		paced_word_t w;
		if (expected_words.size() == 0) begin
			$error("output word with none expected: kind %0d total_sent %0h", kind, total_sent);
			mismatches++;
			return;
		end
		w = expected_words.pop_front();
		cmp_field("kind", TOTAL_W'(w.kind), TOTAL_W'(kind));
		cmp_field("chunk_len", TOTAL_W'(w.chunk_len), TOTAL_W'(chunk_len));
		cmp_field("out_byte", TOTAL_W'(w.byte_val), TOTAL_W'(out_byte));
		cmp_field("last_of_chunk", TOTAL_W'(w.last), TOTAL_W'(last_of_chunk));
		cmp_field("total_sent", w.total, total_sent);
	endfunction

	// output side: checks and ready pacing, including the long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_word();
		if (hold_reqs_seen != hold_reqs_made) begin
			hold_reqs_seen = hold_reqs_made;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= gaps_on ? ($urandom_range(99) >= 14) : 1'b1;
		end
	end

	task automatic send_word(input logic [1:0] act, input logic [7:0] b,
			input logic [LEN_W-1:0] len, input logic first);
		if (gaps_on && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		datagram_len <= len;
		first_of_datagram <= first;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_word(act, b, len, first);
	endtask

	task automatic send_ctrl(input logic [1:0] act);
		send_word(act, 8'($urandom), LEN_W'($urandom), 1'($urandom));
	endtask

	task automatic send_datagram(input logic [LEN_W-1:0] len_field, input int unsigned nbytes);
		for (int unsigned i = 0; i < nbytes; i++)
			send_word(ACT_RECV, 8'($urandom), (i == 0) ? len_field : LEN_W'($urandom), i == 0);
	endtask

	task automatic pull_all();
		while (granted_left != 0)
			send_ctrl(ACT_PULL);
	endtask

	task automatic tick_and_drain(input int unsigned n);
		repeat (n) begin
			send_ctrl(ACT_TICK);
			pull_all();
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_TARGET:   rate_bps = val[TARGET_W-1:0];
		REG_CAPACITY: cap_limit = val[CAP_W-1:0];
		REG_CHUNK:    chunk_limit = val[CHUNK_W-1:0];
		REG_WINDOW:   window_len = val[WIN_W-1:0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_directed_edges();
		send_ctrl(ACT_PULL);
		send_ctrl(ACT_UNUSED);
		send_ctrl(ACT_TICK);
		send_word(ACT_RECV, 8'h00, 12'd0, 1'b1);
		send_word(ACT_RECV, 8'hFF, 12'hFFF, 1'b1);
		send_word(ACT_RECV, 8'hA5, 12'hFFF, 1'b0);
		send_word(ACT_RECV, 8'h5A, 12'h000, 1'b0);
		send_ctrl(ACT_TICK);
		repeat (5) send_ctrl(ACT_PULL);
	endtask

	task automatic test_overflow_and_drop();
		settle();
		// a tiny capacity makes the full ring reachable in a few words
		write_reg(REG_CAPACITY, 30'd16);
		write_reg(REG_CHUNK, 30'd4095);
		write_reg(REG_WINDOW, 30'd1);
		write_reg(REG_TARGET, 30'd1_000_000_000);
		send_datagram(12'd16, 16);
		send_ctrl(ACT_TICK);
		send_datagram(12'd1, 1);
		send_word(ACT_RECV, 8'($urandom), LEN_W'($urandom), 1'b0);
		repeat (20) send_ctrl(ACT_PULL);
		send_datagram(12'd5, 5);
		send_datagram(12'd10, 12);
		send_datagram(12'd4, 8);
		pull_all();
		tick_and_drain(2);
	endtask

	task automatic test_rate_pacing();
		settle();
		write_reg(REG_CAPACITY, 30'h1FFFF);
		write_reg(REG_WINDOW, 30'd65535);
		write_reg(REG_TARGET, 30'd8000);
		write_reg(REG_CHUNK, 30'd1);
		send_datagram(12'd120, 120);
		tick_and_drain(3);
		settle();
		write_reg(REG_CHUNK, 30'd8);
		tick_and_drain(40);
		settle();
		write_reg(REG_WINDOW, 30'd5);
		tick_and_drain(40);
		settle();
		write_reg(REG_TARGET, 30'd0);
		tick_and_drain(10);
		settle();
		write_reg(REG_TARGET, 30'd1);
		tick_and_drain(10);
		settle();
		write_reg(REG_TARGET, 30'd1_000_000_000);
		write_reg(REG_CHUNK, 30'd0);
		tick_and_drain(5);
		settle();
		write_reg(REG_CHUNK, 30'd4095);
		tick_and_drain(2);
	endtask

	task automatic test_output_backpressure();
		settle();
		write_reg(REG_CHUNK, 30'd120);
		send_datagram(12'd120, 120);
		hold_reqs_made <= hold_reqs_made + 1;
		send_ctrl(ACT_TICK);
		pull_all();
		settle();
	endtask

	task automatic test_back_to_back();
		int unsigned filled, len;
		settle();
		gaps_on <= 1'b0;
		write_reg(REG_CAPACITY, 30'd65536);
		write_reg(REG_CHUNK, 30'd2048);
		write_reg(REG_WINDOW, 30'd1);
		write_reg(REG_TARGET, 30'd1_000_000_000);
		repeat (2) begin
			filled = 0;
			while (filled < STREAM_BYTES) begin
				len = $urandom_range(1, STREAM_BYTES - filled);
				send_datagram(LEN_W'(len), len);
				filled += len;
			end
			tick_and_drain(1);
		end
		settle();
		gaps_on <= 1'b1;
	endtask

	task automatic test_random_traffic();
		int unsigned counted, left, eff, r;
		logic [LEN_W-1:0] len_field;
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
			0: begin
				write_reg(REG_TARGET, 30'($urandom_range(8000, 400000)));
				write_reg(REG_CHUNK, 30'($urandom_range(1, 64)));
				write_reg(REG_WINDOW, 30'($urandom_range(1, 50)));
				write_reg(REG_CAPACITY, 30'($urandom_range(2048, 4096)));
			end
			1: begin
				write_reg(REG_TARGET, 30'h3FFF_FFFF);
				write_reg(REG_CHUNK, 30'($urandom_range(2049, 4095)));
				write_reg(REG_WINDOW, 30'd65535);
				write_reg(REG_CAPACITY, 30'd2048);
			end
			2: begin
				write_reg(REG_TARGET, 30'($urandom_range(1, 1_000_000_000)));
				write_reg(REG_CHUNK, 30'($urandom_range(1, 2048)));
				write_reg(REG_WINDOW, 30'($urandom_range(1, 65535)));
				write_reg(REG_CAPACITY, 30'($urandom_range(2048, 131071)));
			end
			default: begin
				write_reg(REG_TARGET, 30'($urandom_range(8000, 80000)));
				write_reg(REG_CHUNK, 30'($urandom_range(1, 16)));
				write_reg(REG_WINDOW, 30'($urandom_range(1, 5)));
				write_reg(REG_CAPACITY, 30'($urandom_range(2048, 2600)));
			end
			endcase
			counted = 0;
			left = 0;
			while (counted < ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 12) begin
					send_ctrl(ACT_TICK);
					counted++;
				end else if (r < 15) begin
					case ($urandom_range(2))
					0: send_ctrl(ACT_UNUSED);
					1: send_ctrl(ACT_PULL);
					default: send_word(ACT_RECV, 8'($urandom), LEN_W'($urandom), 1'b0);
					endcase
				end else if (granted_left != 0 && r < 50) begin
					send_ctrl(ACT_PULL);
					counted++;
				end else begin
					if (left == 0) begin
						r = $urandom_range(99);
						if (r < 85)
							len_field = LEN_W'($urandom_range(1, 200));
						else if (r < 93)
							len_field = LEN_W'($urandom_range(1, 2048));
						else if (r < 96)
							len_field = '0;
						else
							len_field = LEN_W'($urandom_range(2049, 4095));
						eff = (len_field == 0) ? 1 :
							((len_field > MAX_DGRAM) ? int'(MAX_DGRAM) : int'(len_field));
						// some datagrams are cut short by the next first word
						left = ($urandom_range(99) < 10) ? $urandom_range(1, eff) : eff;
						send_word(ACT_RECV, 8'($urandom), len_field, 1'b1);
					end else begin
						send_word(ACT_RECV, 8'($urandom), LEN_W'($urandom), 1'b0);
					end
					left--;
					counted++;
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_overflow_and_drop();
		test_rate_pacing();
		test_output_backpressure();
		test_back_to_back();
		test_random_traffic();
		settle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/rpbf_pkg.sv
rtl/rpbf_ring.sv
rtl/rpbf_pacer.sv
rtl/rpbf_out_stage.sv
rtl/rate_paced_byte_fifo.sv
tb/tb_rate_paced_byte_fifo.sv
